// ===== design/qbd_pkg.sv =====
// shared types, constants and conversion functions of the quantized block dequantizer
package qbd_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned LANE_W = $clog2(LANES);

  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [30:0] INF_MAG      = 31'h7F80_0000;

  typedef enum logic [2:0] {
    FMT_F32 = 3'd0,
    FMT_F16 = 3'd1,
    FMT_Q40 = 3'd2,
    FMT_Q80 = 3'd3,
    FMT_Q4K = 3'd4,
    FMT_Q6K = 3'd5
  } fmt_e;

  typedef enum logic {
    FOP_MUL,
    FOP_SUB
  } fpu_op_e;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_MULN,
    FS_ALIGN,
    FS_ADD,
    FS_NORM,
    FS_ROUND
  } fpu_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RADDR,
    ST_RDATA,
    ST_OPISSUE,
    ST_OPWAIT,
    ST_LANE,
    ST_FLUSH
  } qbd_state_e;

  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } fpu_rsp_t;

  // block length in bytes minus one
  function automatic logic [7:0] blk_bytes_m1(input logic [2:0] mode);
    logic [7:0] r;
    unique case (mode)
      FMT_F32: r = 8'd15;
      FMT_F16: r = 8'd7;
      FMT_Q40: r = 8'd17;
      FMT_Q80: r = 8'd33;
      FMT_Q4K: r = 8'd143;
      FMT_Q6K: r = 8'd209;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // index of the last element of a block
  function automatic logic [7:0] last_elem(input logic [2:0] mode);
    logic [7:0] r;
    unique case (mode)
      FMT_F32, FMT_F16: r = 8'd3;
      FMT_Q40, FMT_Q80: r = 8'd31;
      default:          r = 8'd255;
    endcase
    return r;
  endfunction

  // scale bytes fetched once per block
  function automatic logic [2:0] pro_slots(input logic [2:0] mode);
    logic [2:0] r;
    unique case (mode)
      FMT_Q40, FMT_Q80, FMT_Q6K: r = 3'd2;
      FMT_Q4K:                   r = 3'd4;
      default:                   r = 3'd0;
    endcase
    return r;
  endfunction

  // bytes fetched for each element
  function automatic logic [2:0] elem_slots(input logic [2:0] mode);
    logic [2:0] r;
    unique case (mode)
      FMT_F32, FMT_Q4K: r = 3'd4;
      FMT_F16:          r = 3'd2;
      FMT_Q6K:          r = 3'd3;
      default:          r = 3'd1;
    endcase
    return r;
  endfunction

  // last float operation step of an element
  function automatic logic [1:0] last_step(input logic [2:0] mode);
    logic [1:0] r;
    unique case (mode)
      FMT_Q4K: r = 2'd3;
      FMT_Q6K: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // exact widening of a half to a single, subnormals renormalised
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  p;
    logic [3:0]  sh;
    logic [10:0] mm;
    logic [7:0]  e32;
    logic [31:0] r;
    s   = h[15];
    e   = h[14:10];
    m   = h[9:0];
    p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    sh  = 4'd10 - p;
    mm  = {1'b0, m} << sh;
    e32 = 8'd113 - {4'd0, sh};
    if (e == 5'd0) begin
      if (m == 10'd0) r = {s, 31'd0};
      else            r = {s, e32, mm[9:0], 13'd0};
    end else if (e == 5'h1F) begin
      r = {s, 8'hFF, m, 13'd0};
    end else begin
      r = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
    return r;
  endfunction

  // exact conversion of a small signed integer
  function automatic logic [31:0] int_to_single(input logic signed [8:0] v);
    logic        s;
    logic [8:0]  mag;
    logic [4:0]  p;
    logic [23:0] mx;
    logic [31:0] r;
    s   = v[8];
    mag = s ? 9'(-v) : 9'(v);
    p   = 5'd0;
    for (int i = 0; i < 9; i++) begin
      if (mag[i]) p = 5'(i);
    end
    mx  = {15'd0, mag} << (5'd23 - p);
    if (mag == 9'd0) r = 32'd0;
    else             r = {s, 8'(8'd127 + {3'd0, p}), mx[22:0]};
    return r;
  endfunction

endpackage

// ===== design/quantized_block_dequantizer_unit.sv =====
// top level: byte collection, block buffer and element decode sequencer
// a byte is taken every cycle while idle and no register write is offered; the block's last
// byte starts decoding, no bytes meanwhile. decode: each scale byte is read once per block,
// then per element each byte fetched (1 to 4) is read, each multiply and subtract runs on the
// shared float unit, the lane is stored, and each output word is loaded into its register
// reset is asynchronous, active low: format f32, byte count zero, no result pending
module quantized_block_dequantizer_unit #(
  parameter int unsigned BUFFER_BYTES = 210
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_lane0_o,
  output logic [31:0] value_lane1_o,
  output logic [31:0] value_lane2_o,
  output logic [31:0] value_lane3_o,
  output logic [7:0]  first_index_o,
  output logic        last_in_block_o
);
  import qbd_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  qbd_state_e         st_q, st_d;
  logic [2:0]         mode_q, mode_d;
  logic [7:0]         cnt_q, cnt_d;     // bytes of the current block collected
  logic [7:0]         j_q, j_d;         // element index
  logic [7:0]         fi_q, fi_d;       // index of lane zero
  logic [LANE_W-1:0]  ln_q, ln_d;
  logic               pro_q, pro_d;     // fetching the per-block scale bytes
  logic [1:0]         k_q, k_d;         // byte slot
  logic [1:0]         step_q, step_d;   // float operation step
  logic [7:0]         b_q [4];          // per element bytes
  logic [7:0]         p_q [4];          // per block scale bytes
  logic [31:0]        t0_q, t0_d, t1_q, t1_d;
  logic [31:0]        lane_q [LANES];
  logic               ov_q, ov_d;
  logic [31:0]        olane_q [LANES];
  logic [7:0]         ofi_q, ofi_d;
  logic               olast_q, olast_d;

  logic               in_acc, ram_we, slot_wr, lane_wr, out_ld, elem_last, slot_last;
  logic [7:0]         raddr;
  logic [7:0]         ram_rdata;
  logic [31:0]        lane_val;
  logic [31:0]        hdw, hmw;
  logic [2:0]         u;
  logic [5:0]         sc4, mn4, q6;
  logic [3:0]         nib2, nib4, lo6;
  logic [1:0]         hi6;
  logic signed [8:0]  iv;
  logic [31:0]        ivf;
  fpu_req_t           freq;
  fpu_rsp_t           frsp;

  // register writes and bytes only while idle; a register write goes first
  assign cfg_ready_o = (st_q == ST_IDLE);
  assign in_ready_o  = (st_q == ST_IDLE) && !cfg_valid_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign ram_we      = in_acc && (mode_q <= FMT_Q6K) && !cfg_valid_i;

  assign elem_last = (j_q == last_elem(mode_q));
  assign slot_last = pro_q ? ({1'b0, k_q} == pro_slots(mode_q) - 3'd1)
                           : ({1'b0, k_q} == elem_slots(mode_q) - 3'd1);

  qbd_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(cnt_q)),
    .wdata_i (data_byte_i),
    .raddr_i (AW'(raddr)),
    .rdata_o (ram_rdata)
  );

  qbd_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (freq),
    .rsp_o  (frsp)
  );

  // scales widened from the scale bytes fetched once per block, shared by its elements
  assign hdw = half_to_single({p_q[1], p_q[0]});
  assign hmw = half_to_single({p_q[3], p_q[2]});

  // buffer address of the current byte slot
  always_comb begin
    u = j_q[7:5];
    if (pro_q) begin
      raddr = (mode_q == FMT_Q6K) ? (8'd208 + {6'd0, k_q}) : {6'd0, k_q};
    end else begin
      unique case (mode_q)
        FMT_F32: raddr = {j_q[5:0], k_q};
        FMT_F16: raddr = {j_q[6:0], k_q[0]};
        FMT_Q40: raddr = 8'd2 + {4'd0, j_q[3:0]};
        FMT_Q80: raddr = 8'd2 + {3'd0, j_q[4:0]};
        FMT_Q4K: begin
          unique case (k_q)
            2'd0:    raddr = 8'd8 + {5'd0, u};
            2'd1:    raddr = 8'd4 + {6'd0, u[1:0]};
            2'd2:    raddr = 8'd4 + {5'd0, u};
            default: raddr = 8'd16 + {1'b0, j_q[7:1]};
          endcase
        end
        default: begin
          unique case (k_q)
            2'd0:    raddr = {1'b0, j_q[7:1]};
            2'd1:    raddr = 8'd128 + {2'd0, j_q[7:2]};
            default: raddr = 8'd192 + {4'd0, j_q[7:4]};
          endcase
        end
      endcase
    end
  end

  // field extraction from the fetched bytes
  always_comb begin
    nib2 = j_q[4] ? b_q[0][7:4] : b_q[0][3:0];
    sc4  = j_q[7] ? {b_q[0][3:0], b_q[1][7:6]} : b_q[1][5:0];
    mn4  = j_q[7] ? {b_q[0][7:4], b_q[2][7:6]} : b_q[0][5:0];
    nib4 = j_q[0] ? b_q[3][7:4] : b_q[3][3:0];
    lo6  = j_q[0] ? b_q[0][7:4] : b_q[0][3:0];
    hi6  = 2'(b_q[1] >> {j_q[1:0], 1'b0});
    q6   = {hi6, lo6};
  end

  // operands of the current float step
  always_comb begin
    freq.start = 1'b0;
    freq.op    = FOP_MUL;
    freq.a     = hdw;
    freq.b     = 32'd0;
    iv         = 9'sd0;
    unique case (mode_q)
      FMT_Q40: iv = $signed({5'd0, nib2}) - 9'sd8;
      FMT_Q80: iv = $signed({b_q[0][7], b_q[0]});
      FMT_Q4K: begin
        unique case (step_q)
          2'd0:    iv = $signed({3'd0, sc4});
          2'd1:    iv = $signed({3'd0, mn4});
          default: iv = $signed({5'd0, nib4});
        endcase
      end
      FMT_Q6K: iv = (step_q == 2'd0) ? $signed({b_q[2][7], b_q[2]})
                                     : $signed({3'd0, q6}) - 9'sd32;
      default: iv = 9'sd0;
    endcase
    ivf = int_to_single(iv);
    unique case (mode_q)
      FMT_Q40, FMT_Q80: begin
        freq.a = ivf;
        freq.b = hdw;
      end
      FMT_Q4K: begin
        unique case (step_q)
          2'd0: begin freq.a = hdw;  freq.b = ivf; end
          2'd1: begin freq.a = hmw;  freq.b = ivf; end
          2'd2: begin freq.a = t0_q; freq.b = ivf; end
          default: begin
            freq.a  = t0_q;
            freq.b  = t1_q;
            freq.op = FOP_SUB;
          end
        endcase
      end
      FMT_Q6K: begin
        freq.a = (step_q == 2'd0) ? hdw : t0_q;
        freq.b = ivf;
      end
      default: ;
    endcase
    if ((st_q == ST_OPISSUE) && (mode_q != FMT_F32) && (mode_q != FMT_F16)) begin
      freq.start = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    st_d    = st_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    j_d     = j_q;
    fi_d    = fi_q;
    ln_d    = ln_q;
    pro_d   = pro_q;
    k_d     = k_q;
    step_d  = step_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    ov_d    = ov_q && !out_ready_i;
    ofi_d   = ofi_q;
    olast_d = olast_q;
    slot_wr  = 1'b0;
    lane_wr  = 1'b0;
    lane_val = frsp.res;
    out_ld   = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          mode_d = cfg_data_i;
          cnt_d  = 8'd0;
        end else if (in_acc) begin
          if (mode_q > FMT_Q6K) begin
            cnt_d = 8'd0;
          end else if (cnt_q == blk_bytes_m1(mode_q)) begin
            // block complete: start decoding
            cnt_d = 8'd0;
            j_d   = 8'd0;
            fi_d  = 8'd0;
            ln_d  = '0;
            k_d   = 2'd0;
            pro_d = (pro_slots(mode_q) != 3'd0);
            st_d  = ST_RADDR;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end
      end
      ST_RADDR: st_d = ST_RDATA;
      ST_RDATA: begin
        slot_wr = 1'b1;
        if (slot_last) begin
          k_d = 2'd0;
          if (pro_q) begin
            pro_d = 1'b0;
            st_d  = ST_RADDR;
          end else begin
            step_d = 2'd0;
            st_d   = ST_OPISSUE;
          end
        end else begin
          k_d  = k_q + 2'd1;
          st_d = ST_RADDR;
        end
      end
      ST_OPISSUE: begin
        if (mode_q == FMT_F32) begin
          lane_val = {b_q[3], b_q[2], b_q[1], b_q[0]};
          lane_wr  = 1'b1;
          st_d     = ST_LANE;
        end else if (mode_q == FMT_F16) begin
          lane_val = half_to_single({b_q[1], b_q[0]});
          lane_wr  = 1'b1;
          st_d     = ST_LANE;
        end else begin
          st_d = ST_OPWAIT;
        end
      end
      ST_OPWAIT: begin
        if (frsp.done) begin
          if (step_q == last_step(mode_q)) begin
            lane_wr = 1'b1;
            st_d    = ST_LANE;
          end else begin
            if ((mode_q == FMT_Q4K) && (step_q == 2'd1)) t1_d = frsp.res;
            else                                          t0_d = frsp.res;
            step_d = step_q + 2'd1;
            st_d   = ST_OPISSUE;
          end
        end
      end
      ST_LANE: begin
        if (elem_last || (ln_q == LANE_W'(LANES - 1))) begin
          st_d = ST_FLUSH;
        end else begin
          j_d  = j_q + 8'd1;
          ln_d = ln_q + LANE_W'(1);
          st_d = ST_RADDR;
        end
      end
      ST_FLUSH: begin
        // wait for the output word register to be free
        if (!ov_q || out_ready_i) begin
          out_ld  = 1'b1;
          ov_d    = 1'b1;
          ofi_d   = fi_q;
          olast_d = elem_last;
          if (elem_last) begin
            st_d = ST_IDLE;
          end else begin
            j_d  = j_q + 8'd1;
            ln_d = '0;
            fi_d = fi_q + 8'(LANES);
            st_d = ST_RADDR;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      mode_q <= FMT_F32;
      cnt_q  <= 8'd0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    fi_q    <= fi_d;
    ln_q    <= ln_d;
    pro_q   <= pro_d;
    k_q     <= k_d;
    step_q  <= step_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    ofi_q   <= ofi_d;
    olast_q <= olast_d;
    if (slot_wr) begin
      if (pro_q) p_q[k_q] <= ram_rdata;
      else       b_q[k_q] <= ram_rdata;
    end
    if (lane_wr) lane_q[ln_q] <= lane_val;
    // lanes past the last element of the block read as zero
    for (int l = 0; l < LANES; l++) begin
      if (out_ld) olane_q[l] <= (LANE_W'(l) <= ln_q) ? lane_q[l] : 32'd0;
    end
  end

  assign out_valid_o     = ov_q;
  assign value_lane0_o   = olane_q[0];
  assign value_lane1_o   = olane_q[1];
  assign value_lane2_o   = olane_q[2];
  assign value_lane3_o   = olane_q[3];
  assign first_index_o   = ofi_q;
  assign last_in_block_o = olast_q;

endmodule

// ===== design/qbd_ram.sv =====
// generic simple dual port ram with registered read
module qbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 210
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/qbd_fpu.sv =====
// shared single precision multiply and subtract unit, round to nearest even
module qbd_fpu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qbd_pkg::fpu_req_t req_i,
  output qbd_pkg::fpu_rsp_t rsp_o
);
  import qbd_pkg::*;

  fpu_state_e         st_q, st_d;
  logic [31:0]        a_q, a_d, b_q, b_d, res_q, res_d;
  logic               done_q, done_d, sx_q, sx_d, sub_q, sub_d;
  logic signed [9:0]  ex_q, ex_d;
  logic [26:0]        nm_q, nm_d, xm_q, xm_d, ym_q, ym_d;
  logic [47:0]        prod_q, prod_d;

  // request side classification
  logic        ra_s, rb_s, ra_nan, rb_nan, ra_inf, rb_inf, ra_zero, rb_zero;
  // latched operand unpack
  logic [7:0]  eu_a, eu_b, diff;
  logic [23:0] mu_a, mu_b;
  logic        a_big;
  logic [26:0] mx27, my27, ys;
  logic [53:0] ext;
  logic [27:0] sum;
  logic        up;
  logic [24:0] mr;
  logic signed [9:0] efin;

  always_comb begin
    ra_s    = req_i.a[31];
    rb_s    = (req_i.op == FOP_SUB) ? ~req_i.b[31] : req_i.b[31];
    ra_nan  = (req_i.a[30:23] == 8'hFF) && (req_i.a[22:0] != 23'd0);
    rb_nan  = (req_i.b[30:23] == 8'hFF) && (req_i.b[22:0] != 23'd0);
    ra_inf  = (req_i.a[30:23] == 8'hFF) && (req_i.a[22:0] == 23'd0);
    rb_inf  = (req_i.b[30:23] == 8'hFF) && (req_i.b[22:0] == 23'd0);
    ra_zero = (req_i.a[30:0] == 31'd0);
    rb_zero = (req_i.b[30:0] == 31'd0);

    eu_a = (a_q[30:23] == 8'd0) ? 8'd1 : a_q[30:23];
    eu_b = (b_q[30:23] == 8'd0) ? 8'd1 : b_q[30:23];
    mu_a = {a_q[30:23] != 8'd0, a_q[22:0]};
    mu_b = {b_q[30:23] != 8'd0, b_q[22:0]};

    a_big = {eu_a, mu_a} >= {eu_b, mu_b};
    diff  = a_big ? (eu_a - eu_b) : (eu_b - eu_a);
    mx27  = a_big ? {mu_a, 3'd0} : {mu_b, 3'd0};
    my27  = a_big ? {mu_b, 3'd0} : {mu_a, 3'd0};
    ext   = {my27, 27'd0} >> diff;
    if (diff > 8'd27) ys = {26'd0, my27 != 27'd0};
    else              ys = ext[53:27] | {26'd0, ext[26:0] != 27'd0};

    sum = sub_q ? ({1'b0, xm_q} - {1'b0, ym_q}) : ({1'b0, xm_q} + {1'b0, ym_q});

    up   = nm_q[2] & (nm_q[1] | nm_q[0] | nm_q[3]);
    mr   = {1'b0, nm_q[26:3]} + {24'd0, up};
    efin = ex_q + {9'd0, mr[24]};

    st_d   = st_q;
    a_d    = a_q;
    b_d    = b_q;
    res_d  = res_q;
    done_d = 1'b0;
    sx_d   = sx_q;
    sub_d  = sub_q;
    ex_d   = ex_q;
    nm_d   = nm_q;
    xm_d   = xm_q;
    ym_d   = ym_q;
    prod_d = prod_q;

    unique case (st_q)
      FS_IDLE: begin
        if (req_i.start) begin
          a_d = req_i.a;
          b_d = {rb_s, req_i.b[30:0]};
          priority if (ra_nan) begin
            res_d = req_i.a | QUIET_BIT; done_d = 1'b1;
          end else if (rb_nan) begin
            res_d = req_i.b | QUIET_BIT; done_d = 1'b1;
          end else if (req_i.op == FOP_MUL) begin
            priority if ((ra_inf && rb_zero) || (ra_zero && rb_inf)) begin
              res_d = QNAN_DEFAULT; done_d = 1'b1;
            end else if (ra_inf || rb_inf) begin
              res_d = {ra_s ^ rb_s, INF_MAG}; done_d = 1'b1;
            end else if (ra_zero || rb_zero) begin
              res_d = {ra_s ^ rb_s, 31'd0}; done_d = 1'b1;
            end else begin
              st_d = FS_MUL;
            end
          end else begin
            priority if (ra_inf && rb_inf && (ra_s != rb_s)) begin
              res_d = QNAN_DEFAULT; done_d = 1'b1;
            end else if (ra_inf) begin
              res_d = req_i.a; done_d = 1'b1;
            end else if (rb_inf) begin
              res_d = {rb_s, req_i.b[30:0]}; done_d = 1'b1;
            end else if (ra_zero && rb_zero) begin
              res_d = {ra_s & rb_s, 31'd0}; done_d = 1'b1;
            end else if (rb_zero) begin
              res_d = req_i.a; done_d = 1'b1;
            end else if (ra_zero) begin
              res_d = {rb_s, req_i.b[30:0]}; done_d = 1'b1;
            end else begin
              st_d = FS_ALIGN;
            end
          end
        end
      end
      FS_MUL: begin
        prod_d = mu_a * mu_b;
        ex_d   = $signed({2'd0, eu_a}) + $signed({2'd0, eu_b}) - 10'sd126;
        sx_d   = a_q[31] ^ b_q[31];
        st_d   = FS_MULN;
      end
      FS_MULN: begin
        nm_d = {prod_q[47:22], prod_q[21:0] != 22'd0};
        st_d = FS_NORM;
      end
      FS_ALIGN: begin
        xm_d  = mx27;
        ym_d  = ys;
        ex_d  = $signed({2'd0, a_big ? eu_a : eu_b});
        sx_d  = a_big ? a_q[31] : b_q[31];
        sub_d = a_q[31] != b_q[31];
        st_d  = FS_ADD;
      end
      FS_ADD: begin
        if (sum == 28'd0) begin
          // exact cancellation gives plus zero
          res_d  = 32'd0;
          done_d = 1'b1;
          st_d   = FS_IDLE;
        end else if (sum[27]) begin
          nm_d = {sum[27:2], sum[1] | sum[0]};
          ex_d = ex_q + 10'sd1;
          st_d = FS_NORM;
        end else begin
          nm_d = sum[26:0];
          st_d = FS_NORM;
        end
      end
      FS_NORM: begin
        // one bit of left shift per cycle until the hidden bit is set
        if (nm_q[26]) begin
          st_d = FS_ROUND;
        end else begin
          nm_d = {nm_q[25:0], 1'b0};
          ex_d = ex_q - 10'sd1;
        end
      end
      FS_ROUND: begin
        if (efin >= 10'sd255)   res_d = {sx_q, INF_MAG};
        else if (efin <= 10'sd0) res_d = {sx_q, 31'd0};
        else                     res_d = {sx_q, efin[7:0], mr[22:0]};
        done_d = 1'b1;
        st_d   = FS_IDLE;
      end
      default: st_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= FS_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    res_q  <= res_d;
    sx_q   <= sx_d;
    sub_q  <= sub_d;
    ex_q   <= ex_d;
    nm_q   <= nm_d;
    xm_q   <= xm_d;
    ym_q   <= ym_d;
    prod_q <= prod_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
